/* rtl/core/i2c_bit_level_master_top_assert.svh */
// assertion macros shared by the checker file
`ifndef I2C_BIT_LEVEL_MASTER_TOP_ASSERT_SVH
`define I2C_BIT_LEVEL_MASTER_TOP_ASSERT_SVH

// clocked check, switched off while reset is low
`define I2CM_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define I2CM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// i2cm_pkg
// shared types and constants of the bit-level i2c master
// ----------------------------------------------------------------------------
package i2cm_pkg;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_STOP  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ONE   = 3'd1,
        PH_TWO   = 3'd2,
        PH_THREE = 3'd3
    } phase_t;

    // bit slots per byte: eight data bits and the ack slot
    localparam logic [3:0] SLOT_COUNT = 4'd9;
    localparam logic [3:0] DATA_BITS  = 4'd8;

    typedef struct packed {
        logic       cmd_valid;
        logic [1:0] func;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
    } res_t;

endpackage

/* rtl/core/i2c_bit_level_master_top.sv */
// ----------------------------------------------------------------------------
// i2c_bit_level_master_top
// time-stepped bit-level i2c master with valid/stall channels
// ----------------------------------------------------------------------------
// Each input transfer is one bus delay tick carrying the sampled sda level and,
// while the master is idle, an optional command (start or repeated start,
// stop, write byte with ack slot, read byte with ack or nack). Every input
// transfer produces exactly one output transfer with the scl level, the sda
// pull-down, busy, done, the received byte and the sampled ack. The block takes
// one tick per clock cycle when the output side does not stall; a result passes
// through the input register and then the result register. Start and stop last
// 4 ticks, a byte 19 ticks; a command offered while busy is ignored. The
// sequencer update between the two registers is combinational.
module i2c_bit_level_master_top
    import i2cm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       cmd_valid,
    input  logic [1:0] func,
    input  logic [7:0] tx_byte,
    input  logic       send_ack,
    input  logic       sda_in,
    // output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       scl_out,
    output logic       sda_drive_low,
    output logic       busy_res,
    output logic       done_res,
    output logic [7:0] rx_byte,
    output logic       ack_seen
);

    // input register stage
    logic  s1_valid_reg, s1_valid_next;
    item_t s1_item_reg;

    // result register stage
    logic  out_valid_reg, out_valid_next;
    res_t  out_res_reg;

    res_t  step_res;
    logic  adv;
    logic  fire;
    logic  in_take;

    // pipeline moves when the result register is empty or being drained
    assign adv     = !out_valid_reg || !out_stall;
    assign fire    = s1_valid_reg && adv;
    assign in_stall = s1_valid_reg && !adv;
    assign in_take = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (adv)
            s1_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv)
            out_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg.cmd_valid <= cmd_valid;
            s1_item_reg.func      <= func;
            s1_item_reg.tx_byte   <= tx_byte;
            s1_item_reg.send_ack  <= send_ack;
            s1_item_reg.sda_in    <= sda_in;
        end
        if (fire)
            out_res_reg <= step_res;
    end

    // sequencer: one phase per accepted tick
    i2cm_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (s1_item_reg),
        .res   (step_res)
    );

    assign out_valid     = out_valid_reg;
    assign scl_out       = out_res_reg.scl_out;
    assign sda_drive_low = out_res_reg.sda_drive_low;
    assign busy_res      = out_res_reg.busy_res;
    assign done_res      = out_res_reg.done_res;
    assign rx_byte       = out_res_reg.rx_byte;
    assign ack_seen      = out_res_reg.ack_seen;

endmodule

/* rtl/core/i2cm_core.sv */
// ----------------------------------------------------------------------------
// i2cm_core
// bus sequencer state and one-tick update of the i2c master
// ----------------------------------------------------------------------------
module i2cm_core
    import i2cm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  fire,
    input  item_t item,
    output res_t  res
);

    cmd_t       cmd_reg, cmd_next;
    phase_t     phase_reg, phase_next;
    logic [3:0] bit_cnt_reg, bit_cnt_next;
    logic [7:0] shift_reg, shift_next;
    logic       ack_choice_reg, ack_choice_next;
    logic       scl_reg, scl_next;
    logic       sda_low_reg, sda_low_next;
    logic       busy_reg, busy_next;

    logic       done;
    logic [7:0] rx;
    logic       acks;
    logic       do_low;
    cmd_t       cmd_sel;
    logic [7:0] shift_base;
    logic [3:0] bit_base;
    logic       ack_base;
    logic       is_start;

    assign is_start = (cmd_reg == CMD_START);

    // phase sequencing
    always_comb
    begin
        phase_next = phase_reg;
        if (!busy_reg)
        begin
            if (item.cmd_valid)
            begin
                phase_next = PH_ONE;
            end
        end
        else if (cmd_reg inside {CMD_START, CMD_STOP})
        begin
            unique case (phase_reg)
                PH_ONE:   phase_next = PH_TWO;
                PH_TWO:   phase_next = PH_THREE;
                PH_THREE: phase_next = PH_IDLE;
                default:  phase_next = PH_IDLE;
            endcase
        end
        else
        begin
            unique case (phase_reg)
                PH_ONE:  phase_next = PH_TWO;
                PH_TWO:  phase_next = (bit_cnt_reg >= SLOT_COUNT) ? PH_IDLE : PH_ONE;
                default: phase_next = PH_IDLE;
            endcase
        end
    end

    // line levels, shifter and results
    always_comb
    begin
        cmd_next        = cmd_reg;
        bit_cnt_next    = bit_cnt_reg;
        shift_next      = shift_reg;
        ack_choice_next = ack_choice_reg;
        scl_next        = scl_reg;
        sda_low_next    = sda_low_reg;
        busy_next       = busy_reg;
        done            = 1'b0;
        rx              = 8'd0;
        acks            = 1'b0;
        do_low          = 1'b0;
        cmd_sel         = cmd_reg;
        shift_base      = shift_reg;
        bit_base        = bit_cnt_reg;
        ack_base        = ack_choice_reg;

        if (!busy_reg)
        begin
            if (item.cmd_valid)
            begin
                cmd_next  = cmd_t'(item.func);
                busy_next = 1'b1;
                unique case (cmd_t'(item.func)) inside
                    CMD_START: sda_low_next = 1'b0;
                    CMD_STOP:  scl_next     = 1'b0;
                    CMD_WRITE, CMD_READ:
                    begin
                        cmd_sel    = cmd_t'(item.func);
                        shift_base = (cmd_t'(item.func) == CMD_WRITE) ? item.tx_byte : 8'd0;
                        ack_base   = item.send_ack;
                        bit_base   = 4'd0;
                        do_low     = 1'b1;
                    end
                    default: busy_next = 1'b1;
                endcase
            end
        end
        else if (cmd_reg inside {CMD_START, CMD_STOP})
        begin
            unique case (phase_reg)
                PH_ONE:
                begin
                    if (is_start) scl_next = 1'b1;
                    else          sda_low_next = 1'b1;
                end
                PH_TWO:
                begin
                    if (is_start) sda_low_next = 1'b1;
                    else          scl_next = 1'b1;
                end
                PH_THREE:
                begin
                    if (is_start) scl_next = 1'b0;
                    else          sda_low_next = 1'b0;
                    done      = 1'b1;
                    busy_next = 1'b0;
                end
                default: busy_next = 1'b0;
            endcase
        end
        else
        begin
            unique case (phase_reg)
                PH_ONE: scl_next = 1'b1;
                PH_TWO:
                begin
                    if (bit_cnt_reg >= SLOT_COUNT)
                    begin
                        if (cmd_reg == CMD_WRITE) acks = item.sda_in;
                        else                      rx   = shift_reg;
                        scl_next  = 1'b0;
                        done      = 1'b1;
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        do_low = 1'b1;
                    end
                end
                default: busy_next = 1'b0;
            endcase
        end

        // low phase of a bit slot: scl falls, sda set for the slot
        if (do_low)
        begin
            if (cmd_sel == CMD_READ)
            begin
                if (bit_base >= 4'd1 && bit_base <= DATA_BITS)
                    shift_next = {shift_base[6:0], item.sda_in};
                else
                    shift_next = shift_base;
                sda_low_next = (bit_base == DATA_BITS) ? ack_base : 1'b0;
            end
            else
            begin
                if (bit_base < DATA_BITS)
                begin
                    sda_low_next = ~shift_base[7];
                    shift_next   = {shift_base[6:0], 1'b0};
                end
                else
                begin
                    sda_low_next = 1'b0;
                    shift_next   = shift_base;
                end
            end
            scl_next        = 1'b0;
            bit_cnt_next    = bit_base + 4'd1;
            ack_choice_next = ack_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg        <= CMD_START;
            phase_reg      <= PH_IDLE;
            bit_cnt_reg    <= 4'd0;
            shift_reg      <= 8'd0;
            ack_choice_reg <= 1'b0;
            scl_reg        <= 1'b1;
            sda_low_reg    <= 1'b0;
            busy_reg       <= 1'b0;
        end
        else if (fire)
        begin
            cmd_reg        <= cmd_next;
            phase_reg      <= phase_next;
            bit_cnt_reg    <= bit_cnt_next;
            shift_reg      <= shift_next;
            ack_choice_reg <= ack_choice_next;
            scl_reg        <= scl_next;
            sda_low_reg    <= sda_low_next;
            busy_reg       <= busy_next;
        end
    end

    assign res.scl_out       = scl_next;
    assign res.sda_drive_low = sda_low_next;
    assign res.busy_res      = busy_next;
    assign res.done_res      = done;
    assign res.rx_byte       = rx;
    assign res.ack_seen      = acks;

endmodule

/* rtl/core/i2cm_checker.sv */
// ----------------------------------------------------------------------------
// i2cm_checker
// port-level checks of the i2c master, bound to the top level
// ----------------------------------------------------------------------------
`include "i2c_bit_level_master_top_assert.svh"

module i2cm_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic       scl_out,
    input logic       sda_drive_low,
    input logic       busy_res,
    input logic       done_res,
    input logic [7:0] rx_byte,
    input logic       ack_seen
);

    logic        held;
    logic [12:0] res_bits;

    assign held     = out_valid && out_stall;
    assign res_bits = {scl_out, sda_drive_low, busy_res, done_res, rx_byte, ack_seen};

    // stalled result holds
    `I2CM_ASSERT_CLK(a_out_hold, held |=> out_valid && $stable(res_bits), "stalled result changed")

    // a finished command leaves the master idle
    `I2CM_ASSERT_CLK(a_done_idle, out_valid && done_res |-> !busy_res, "done while still busy")

    // received byte and ack only shown on completion
    `I2CM_ASSERT_CLK(a_rx_done, out_valid && (|rx_byte || ack_seen) |-> done_res, "data without done")

    // nothing leaves and nothing is held off during reset
    `I2CM_ASSERT_ALWAYS(a_rst_quiet, !rst_n |-> !out_valid && !in_stall, "activity in reset")

endmodule

bind i2c_bit_level_master_top i2cm_checker u_i2cm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .scl_out       (scl_out),
    .sda_drive_low (sda_drive_low),
    .busy_res      (busy_res),
    .done_res      (done_res),
    .rx_byte       (rx_byte),
    .ack_seen      (ack_seen)
);

/* test/i2c_bit_level_master_top_test.sv */
// ----------------------------------------------------------------------------
// i2c_bit_level_master_top_test
// self-checking bench for the time-stepped bit-level i2c master
// ----------------------------------------------------------------------------
// Each tick transfer is fed to the block and also to a cycle-free model of the
// sequencer. The model keeps the bus levels expected for every tick in order,
// and each output transfer is checked against the oldest one, field by field.
// A short table of directed ticks runs first: reset levels, start, stop, write
// of all ones and all zeros with ack and nack, read with ack and nack, and
// commands offered while busy or on the done tick. Random i2c transactions
// follow, mostly well formed (start, address write, data writes and reads,
// stop) with some stray commands, under several idle and stall mixes and one
// long output hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module i2c_bit_level_master_top_test;
    import i2cm_pkg::*;

    localparam int RANDOM_TICKS = 740;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_NS     = 2_000_000;
    localparam int ROW_COUNT    = 22;

    // one row of the directed tick table; want is used only where chk is set
    typedef struct packed {
        item_t      stim;
        logic [4:0] reps;
        logic       chk;
        res_t       want;
    } tick_row_t;

    // stim: cmd_valid, func, tx_byte, send_ack, sda_in
    // want: scl_out, sda_drive_low, busy_res, done_res, rx_byte, ack_seen
    localparam tick_row_t TICK_TABLE [ROW_COUNT] = '{
        // idle after reset, stray fields ignored
        '{'{1'b0, CMD_READ,  8'hFF, 1'b1, 1'b1}, 5'd1,  1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}},
        // start, with a stop offered while busy and a read on the done tick
        '{'{1'b1, CMD_START, 8'h00, 1'b0, 1'b0}, 5'd1,  1'b1, '{1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
        '{'{1'b1, CMD_STOP,  8'h00, 1'b0, 1'b0}, 5'd1,  1'b1, '{1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
        '{'{1'b0, CMD_START, 8'h00, 1'b0, 1'b0}, 5'd1,  1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
        '{'{1'b1, CMD_READ,  8'h00, 1'b1, 1'b0}, 5'd1,  1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 8'h00, 1'b0}},
        // write all ones, slave answers nack
        '{'{1'b1, CMD_WRITE, 8'hFF, 1'b0, 1'b0}, 5'd1,  1'b0, '0},
        '{'{1'b1, CMD_START, 8'h00, 1'b1, 1'b0}, 5'd17, 1'b0, '0},
        '{'{1'b0, CMD_WRITE, 8'h00, 1'b0, 1'b1}, 5'd1,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b1}},
        // write all zeros, slave answers ack
        '{'{1'b1, CMD_WRITE, 8'h00, 1'b1, 1'b1}, 5'd1,  1'b0, '0},
        '{'{1'b0, CMD_STOP,  8'hFF, 1'b0, 1'b1}, 5'd17, 1'b0, '0},
        '{'{1'b0, CMD_STOP,  8'hFF, 1'b0, 1'b0}, 5'd1,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0}},
        // read all ones and ack it
        '{'{1'b1, CMD_READ,  8'h00, 1'b1, 1'b1}, 5'd1,  1'b0, '0},
        '{'{1'b1, CMD_WRITE, 8'h5A, 1'b0, 1'b1}, 5'd17, 1'b0, '0},
        '{'{1'b0, CMD_READ,  8'h00, 1'b0, 1'b1}, 5'd1,  1'b1, '{1'b0, 1'b1, 1'b0, 1'b1, 8'hFF, 1'b0}},
        // read all zeros and nack it
        '{'{1'b1, CMD_READ,  8'hFF, 1'b0, 1'b0}, 5'd1,  1'b0, '0},
        '{'{1'b0, CMD_READ,  8'hFF, 1'b1, 1'b0}, 5'd17, 1'b0, '0},
        '{'{1'b0, CMD_READ,  8'h00, 1'b0, 1'b0}, 5'd1,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0}},
        // stop from a low bus
        '{'{1'b1, CMD_STOP,  8'h00, 1'b0, 1'b0}, 5'd1,  1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
        '{'{1'b0, CMD_STOP,  8'h00, 1'b0, 1'b0}, 5'd1,  1'b1, '{1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
        '{'{1'b1, CMD_START, 8'h00, 1'b0, 1'b0}, 5'd1,  1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
        '{'{1'b0, CMD_STOP,  8'h00, 1'b0, 1'b0}, 5'd1,  1'b1, '{1'b1, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0}},
        // idle again, levels held
        '{'{1'b0, CMD_WRITE, 8'hA5, 1'b1, 1'b0}, 5'd1,  1'b1, '{1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0}}
    };

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       cmd_valid;
    logic [1:0] func;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
    logic       out_valid;
    logic       out_stall;
    logic       scl_out;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;

    // model of the sequencer
    cmd_t       cur_cmd;
    phase_t     cur_phase;
    logic [3:0] slot_cnt;
    logic [7:0] shreg;
    logic       ack_sel;
    logic       scl_lvl;
    logic       sda_pull;
    logic       busy_lvl;

    // bus levels expected per tick, oldest first
    res_t       expected_levels [$];
    // commands of the transaction in progress
    item_t      planned_cmds [$];

    int         err_count;
    int         result_idx;
    int         snd_idle_pct;
    int         rcv_stall_pct;
    bit         hold_req;
    bit         hold_sent;
    int         hold_left;
    int         n_useful;
    int         row;
    int         rep;
    int         seg;
    item_t      next_tick;

    i2c_bit_level_master_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd_valid     (cmd_valid),
        .func          (func),
        .tx_byte       (tx_byte),
        .send_ack      (send_ack),
        .sda_in        (sda_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .scl_out       (scl_out),
        .sda_drive_low (sda_drive_low),
        .busy_res      (busy_res),
        .done_res      (done_res),
        .rx_byte       (rx_byte),
        .ack_seen      (ack_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #(LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

    // low phase of a bit slot: scl falls, sda is set, read bits shift in
    function automatic void slot_low_phase(logic sda_now);
        if (cur_cmd == CMD_READ)
        begin
            if (slot_cnt >= 4'd1 && slot_cnt <= DATA_BITS)
                shreg = {shreg[6:0], sda_now};
            sda_pull = (slot_cnt == DATA_BITS) ? ack_sel : 1'b0;
        end
        else if (slot_cnt < DATA_BITS)
        begin
            sda_pull = ~shreg[7];
            shreg    = {shreg[6:0], 1'b0};
        end
        else
            sda_pull = 1'b0;
        scl_lvl   = 1'b0;
        slot_cnt  = slot_cnt + 4'd1;
        cur_phase = PH_ONE;
    endfunction

    // advances the model by one tick and returns the levels it leaves
    function automatic res_t next_bus_levels(item_t it);
        res_t r;
        r = '0;
        if (!busy_lvl)
        begin
            if (it.cmd_valid)
            begin
                cur_cmd  = cmd_t'(it.func);
                busy_lvl = 1'b1;
                case (cur_cmd)
                    CMD_START:
                    begin
                        sda_pull  = 1'b0;
                        cur_phase = PH_ONE;
                    end
                    CMD_STOP:
                    begin
                        scl_lvl   = 1'b0;
                        cur_phase = PH_ONE;
                    end
                    default:
                    begin
                        shreg    = (cur_cmd == CMD_WRITE) ? it.tx_byte : 8'h00;
                        ack_sel  = it.send_ack;
                        slot_cnt = 4'd0;
                        slot_low_phase(it.sda_in);
                    end
                endcase
            end
        end
        else if (cur_cmd == CMD_START || cur_cmd == CMD_STOP)
        begin
            // start: scl up, sda down, scl down; stop: sda down, scl up, sda up
            case (cur_phase)
                PH_ONE:
                begin
                    if (cur_cmd == CMD_START) scl_lvl = 1'b1; else sda_pull = 1'b1;
                    cur_phase = PH_TWO;
                end
                PH_TWO:
                begin
                    if (cur_cmd == CMD_START) sda_pull = 1'b1; else scl_lvl = 1'b1;
                    cur_phase = PH_THREE;
                end
                PH_THREE:
                begin
                    if (cur_cmd == CMD_START) scl_lvl = 1'b0; else sda_pull = 1'b0;
                    r.done_res = 1'b1;
                    cur_phase  = PH_IDLE;
                    busy_lvl   = 1'b0;
                end
                default:
                begin
                    cur_phase = PH_IDLE;
                    busy_lvl  = 1'b0;
                end
            endcase
        end
        else if (cur_phase == PH_ONE)
        begin
            scl_lvl   = 1'b1;
            cur_phase = PH_TWO;
        end
        else if (cur_phase == PH_TWO)
        begin
            if (slot_cnt >= SLOT_COUNT)
            begin
                // end of the ack slot: sample and close the byte
                if (cur_cmd == CMD_WRITE)
                    r.ack_seen = it.sda_in;
                else
                    r.rx_byte = shreg;
                scl_lvl    = 1'b0;
                r.done_res = 1'b1;
                cur_phase  = PH_IDLE;
                busy_lvl   = 1'b0;
            end
            else
                slot_low_phase(it.sda_in);
        end
        else
        begin
            cur_phase = PH_IDLE;
            busy_lvl  = 1'b0;
        end
        r.scl_out       = scl_lvl;
        r.sda_drive_low = sda_pull;
        r.busy_res      = busy_lvl;
        return r;
    endfunction

    task automatic report_error(string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        err_count++;
    endtask

    task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_error($sformatf("result %0d %s got %h expected %h",
                                   result_idx, name, got, want));
    endtask

    // offers one tick, waits for the transfer, then records its expected levels
    task automatic drive_tick(item_t it, logic chk, res_t typed);
        res_t predicted;
        in_valid  <= 1'b1;
        cmd_valid <= it.cmd_valid;
        func      <= it.func;
        tx_byte   <= it.tx_byte;
        send_ack  <= it.send_ack;
        sda_in    <= it.sda_in;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        predicted = next_bus_levels(it);
        expected_levels.push_back(chk ? typed : predicted);
    endtask

    // queues the commands of one bus transaction
    task automatic plan_transaction();
        item_t p;
        int    n;
        p           = '0;
        p.cmd_valid = 1'b1;
        if ($urandom_range(0, 99) < 85)
        begin
            // start, address byte, a few data bytes, maybe a repeated start, stop
            p.func = CMD_START;
            planned_cmds.push_back(p);
            p.func     = CMD_WRITE;
            p.tx_byte  = 8'($urandom);
            p.send_ack = 1'($urandom);
            planned_cmds.push_back(p);
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
            begin
                p.func     = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
                p.tx_byte  = 8'($urandom);
                p.send_ack = (i < n - 1) ? 1'b1 : ($urandom_range(0, 3) == 0);
                planned_cmds.push_back(p);
            end
            if ($urandom_range(0, 4) == 0)
            begin
                p.func = CMD_START;
                planned_cmds.push_back(p);
                p.func    = CMD_READ;
                p.tx_byte = 8'($urandom);
                planned_cmds.push_back(p);
            end
            p.func = CMD_STOP;
            planned_cmds.push_back(p);
        end
        else
        begin
            // stray command outside any transaction
            p.func     = 2'($urandom);
            p.tx_byte  = 8'($urandom);
            p.send_ack = 1'($urandom);
            planned_cmds.push_back(p);
        end
    endtask

    // sender: reset, directed table, then random transactions
    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        cmd_valid     = 1'b0;
        func          = CMD_START;
        tx_byte       = 8'h00;
        send_ack      = 1'b0;
        sda_in        = 1'b1;
        err_count     = 0;
        result_idx    = 0;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        hold_req      = 1'b0;
        hold_sent     = 1'b0;
        cur_cmd       = CMD_START;
        cur_phase     = PH_IDLE;
        slot_cnt      = 4'd0;
        shreg         = 8'h00;
        ack_sel       = 1'b0;
        scl_lvl       = 1'b1;
        sda_pull      = 1'b0;
        busy_lvl      = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < ROW_COUNT; row++)
            for (rep = 0; rep < TICK_TABLE[row].reps; rep++)
                drive_tick(TICK_TABLE[row].stim, TICK_TABLE[row].chk, TICK_TABLE[row].want);

        n_useful = 0;
        while (n_useful < RANDOM_TICKS)
        begin
            // idle mix per quarter: none, sender gaps, receiver stalls, both
            seg = n_useful * 4 / RANDOM_TICKS;
            case (seg)
                0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
                1: begin snd_idle_pct = 60; rcv_stall_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_stall_pct = 60; end
                default: begin snd_idle_pct = 24; rcv_stall_pct = 24; end
            endcase
            // long output hold-off while the sender keeps pushing
            if (n_useful == 40 && !hold_sent)
            begin
                hold_req  = 1'b1;
                hold_sent = 1'b1;
            end
            while ($urandom_range(0, 99) < snd_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            next_tick = '0;
            if (busy_lvl)
            begin
                // commands are ignored here, so offer anything
                next_tick.cmd_valid = 1'($urandom);
                next_tick.func      = 2'($urandom);
                next_tick.tx_byte   = 8'($urandom);
                next_tick.send_ack  = 1'($urandom);
                n_useful++;
            end
            else if ($urandom_range(0, 99) < 75)
            begin
                if (planned_cmds.size() == 0)
                    plan_transaction();
                next_tick = planned_cmds.pop_front();
                n_useful++;
            end
            else
            begin
                // idle tick, payload fields have no effect
                next_tick.func     = 2'($urandom);
                next_tick.tx_byte  = 8'($urandom);
                next_tick.send_ack = 1'($urandom);
            end
            next_tick.sda_in = 1'($urandom);
            drive_tick(next_tick, 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (expected_levels.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // receiver: checks each output transfer and drives the stall
    initial
    begin
        res_t got;
        res_t want;
        out_stall = 1'b0;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                got = {scl_out, sda_drive_low, busy_res, done_res, rx_byte, ack_seen};
                if (expected_levels.size() == 0)
                    report_error($sformatf("result %0d arrived with nothing expected",
                                           result_idx));
                else
                begin
                    want = expected_levels.pop_front();
                    compare_field("scl_out", 8'(got.scl_out), 8'(want.scl_out));
                    compare_field("sda_drive_low", 8'(got.sda_drive_low),
                                  8'(want.sda_drive_low));
                    compare_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
                    compare_field("done_res", 8'(got.done_res), 8'(want.done_res));
                    compare_field("rx_byte", got.rx_byte, want.rx_byte);
                    compare_field("ack_seen", 8'(got.ack_seen), 8'(want.ack_seen));
                end
                result_idx++;
            end
            // long hold-off, counted here, otherwise random stalls
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
        end
    end

endmodule
